// ===== src/led_blink_dim_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// LED blink/dim controller: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_DIM_CONTROLLER_UNIT_DEFINES_SVH
`define LED_BLINK_DIM_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define LBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lbd_pkg
// Types and constants shared by the LED blink/dim controller modules.
// ----------------------------------------------------------------------------
package lbd_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STEPS_W  = 8;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // event kinds carried on in_tuser
  typedef enum logic [1:0] {
    EV_BUTTON = 2'd0,
    EV_MAIN   = 2'd1,
    EV_AUX    = 2'd2,
    EV_NONE   = 2'd3
  } ev_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEPS   = 3'd4;

  // reset values
  localparam logic [PERIOD_W-1:0] RST_BLINK_PERIOD = 16'd31250;
  localparam logic [PERIOD_W-1:0] RST_HOLD_PERIOD  = 16'd62500;
  localparam logic [PERIOD_W-1:0] RST_DIM_PERIOD   = 16'd1;
  localparam logic [PERIOD_W-1:0] RST_RAMP_PERIOD  = 16'd305;
  localparam logic [STEPS_W-1:0]  RST_HOLD_STEPS   = 8'd204;

  // prescaler codes
  localparam logic [CODE_W-1:0] CODE_MAX     = 3'd7;
  localparam logic [CODE_W-1:0] CODE_MIN     = 3'd3;
  localparam logic [CODE_W-1:0] PRESCALE_DIM = 3'd5;
  localparam logic [STEPS_W-1:0] HOLD_MAX    = 8'd255;

  typedef struct packed {
    logic [PERIOD_W-1:0] blink_period;
    logic [PERIOD_W-1:0] hold_period;
    logic [PERIOD_W-1:0] dim_period;
    logic [PERIOD_W-1:0] ramp_period;
    logic [STEPS_W-1:0]  hold_steps;
  } lbd_cfg_t;

  // result beat, last member in the lowest bits
  typedef struct packed {
    logic                aux_restart;
    logic                aux_enable;
    logic [PERIOD_W-1:0] aux_period;
    logic                main_restart;
    logic [PERIOD_W-1:0] main_period;
    logic [CODE_W-1:0]   main_prescale;
    logic                dim_mode;
    logic                led_on;
  } lbd_result_t;

endpackage

// ===== src/lbd_cfg.sv =====
// ----------------------------------------------------------------------------
// lbd_cfg
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
module lbd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbd_pkg::PERIOD_W-1:0]  cfg_data,
  output lbd_pkg::lbd_cfg_t             cfg
);
  import lbd_pkg::*;

  lbd_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_period <= RST_BLINK_PERIOD;
      cfg_r.hold_period  <= RST_HOLD_PERIOD;
      cfg_r.dim_period   <= RST_DIM_PERIOD;
      cfg_r.ramp_period  <= RST_RAMP_PERIOD;
      cfg_r.hold_steps   <= RST_HOLD_STEPS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLINK_PERIOD: cfg_r.blink_period <= cfg_data;
        REG_HOLD_PERIOD:  cfg_r.hold_period  <= cfg_data;
        REG_DIM_PERIOD:   cfg_r.dim_period   <= cfg_data;
        REG_RAMP_PERIOD:  cfg_r.ramp_period  <= cfg_data;
        REG_HOLD_STEPS:   cfg_r.hold_steps   <= cfg_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/lbd_core.sv =====
// ----------------------------------------------------------------------------
// lbd_core
// Controller state and the single-pass event update that forms each result.
// ----------------------------------------------------------------------------
module lbd_core #(
  parameter int unsigned PWM_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  lbd_pkg::ev_t         func,
  input  logic                 button_low,
  input  lbd_pkg::lbd_cfg_t    cfg,
  output lbd_pkg::lbd_result_t res
);
  import lbd_pkg::*;
  `include "led_blink_dim_controller_unit_defines.svh"

  localparam logic [PWM_BITS-1:0] DUTY_MAX = '1;
  localparam logic [PWM_BITS-1:0] PWM_ONE  = PWM_BITS'(1);

  logic                in_dim_r,       in_dim_nxt;
  logic [CODE_W-1:0]   blink_code_r,   blink_code_nxt;
  logic [CODE_W-1:0]   saved_speed_r,  saved_speed_nxt;
  logic [PWM_BITS-1:0] duty_level_r,   duty_level_nxt;
  logic [PWM_BITS-1:0] pwm_phase_r,    pwm_phase_nxt;
  logic                ramp_up_r,      ramp_up_nxt;
  logic [STEPS_W-1:0]  hold_count_r,   hold_count_nxt;
  logic                expect_press_r, expect_press_nxt;
  logic                led_level_r,    led_level_nxt;
  logic                aux_running_r,  aux_running_nxt;

  logic              main_restart;
  logic              aux_restart;
  logic              hold_incr;
  logic [CODE_W:0]   speed_sum;
  logic [CODE_W-1:0] speed_sat;

  // slower blink speed on return from dim, clamped at the top code
  assign speed_sum = {1'b0, saved_speed_r} + (CODE_W+1)'(2);
  assign speed_sat = (speed_sum > {1'b0, CODE_MAX}) ? CODE_MAX : speed_sum[CODE_W-1:0];

  // event update
  always_comb begin
    in_dim_nxt       = in_dim_r;
    blink_code_nxt   = blink_code_r;
    saved_speed_nxt  = saved_speed_r;
    duty_level_nxt   = duty_level_r;
    pwm_phase_nxt    = pwm_phase_r;
    ramp_up_nxt      = ramp_up_r;
    hold_count_nxt   = hold_count_r;
    expect_press_nxt = expect_press_r;
    led_level_nxt    = led_level_r;
    aux_running_nxt  = aux_running_r;
    main_restart     = 1'b0;
    aux_restart      = 1'b0;
    hold_incr        = 1'b0;
    case (func)
      EV_BUTTON: begin
        if (!in_dim_r) begin
          if (expect_press_r) begin
            blink_code_nxt  = (blink_code_r <= CODE_MIN) ? CODE_MAX
                                                         : blink_code_r - CODE_W'(1);
            aux_restart     = 1'b1;
            aux_running_nxt = 1'b1;
          end else begin
            aux_running_nxt = 1'b0;
          end
        end
        hold_count_nxt   = '0;
        expect_press_nxt = !expect_press_r;
      end
      EV_MAIN: begin
        if (in_dim_r) begin
          led_level_nxt = (pwm_phase_r < duty_level_r);
          pwm_phase_nxt = pwm_phase_r + PWM_ONE;
        end else begin
          led_level_nxt = !led_level_r;
        end
      end
      EV_AUX: begin
        if (!in_dim_r) begin
          // hold timer expired: go dim
          in_dim_nxt      = 1'b1;
          saved_speed_nxt = blink_code_r;
          aux_running_nxt = 1'b1;
          main_restart    = 1'b1;
          aux_restart     = 1'b1;
        end else begin
          if (hold_count_r < HOLD_MAX) begin
            hold_count_nxt = hold_count_r + STEPS_W'(1);
            hold_incr      = 1'b1;
          end
          // triangle ramp turns at both ends
          if (duty_level_r == DUTY_MAX) ramp_up_nxt = 1'b0;
          if (duty_level_r == '0)       ramp_up_nxt = 1'b1;
          duty_level_nxt = ramp_up_nxt ? duty_level_r + PWM_ONE
                                       : duty_level_r - PWM_ONE;
          if (button_low) begin
            if (hold_incr && (hold_count_nxt == cfg.hold_steps)) begin
              saved_speed_nxt = speed_sat;
              blink_code_nxt  = speed_sat;
              in_dim_nxt      = 1'b0;
              aux_running_nxt = 1'b0;
              main_restart    = 1'b1;
              aux_restart     = 1'b1;
            end
          end else begin
            hold_count_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // result from the state after the event
  always_comb begin
    res.led_on        = led_level_nxt;
    res.dim_mode      = in_dim_nxt;
    res.main_prescale = in_dim_nxt ? PRESCALE_DIM : blink_code_nxt;
    res.main_period   = in_dim_nxt ? cfg.dim_period : cfg.blink_period;
    res.main_restart  = main_restart;
    res.aux_period    = in_dim_nxt ? cfg.ramp_period : cfg.hold_period;
    res.aux_enable    = aux_running_nxt;
    res.aux_restart   = aux_restart;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_dim_r       <= 1'b0;
      blink_code_r   <= CODE_MAX;
      saved_speed_r  <= CODE_MAX;
      duty_level_r   <= '0;
      pwm_phase_r    <= '0;
      ramp_up_r      <= 1'b1;
      hold_count_r   <= '0;
      expect_press_r <= 1'b1;
      led_level_r    <= 1'b0;
      aux_running_r  <= 1'b0;
    end else if (step_en) begin
      in_dim_r       <= in_dim_nxt;
      blink_code_r   <= blink_code_nxt;
      saved_speed_r  <= saved_speed_nxt;
      duty_level_r   <= duty_level_nxt;
      pwm_phase_r    <= pwm_phase_nxt;
      ramp_up_r      <= ramp_up_nxt;
      hold_count_r   <= hold_count_nxt;
      expect_press_r <= expect_press_nxt;
      led_level_r    <= led_level_nxt;
      aux_running_r  <= aux_running_nxt;
    end
  end

  // blink codes never drop below CODE_MIN, the code at which the button wraps
  `LBD_ASSERT_NOW(a_code_range, 1'b1, (blink_code_r >= CODE_MIN) && (saved_speed_r >= CODE_MIN), "blink code out of range")
  // the aux timer always runs while dimming
  `LBD_ASSERT_NOW(a_dim_aux_runs, in_dim_r, aux_running_r, "aux timer stopped in dim mode")
  // a main restart goes with a mode change
  `LBD_ASSERT_NEXT(a_restart_mode, step_en && res.main_restart, in_dim_r != $past(in_dim_r), "main restart without mode change")

endmodule

// ===== src/led_blink_dim_controller_unit.sv =====
// ----------------------------------------------------------------------------
// led_blink_dim_controller_unit
// Event-driven two-mode LED controller: blink and PWM dim with triangle ramp.
// ----------------------------------------------------------------------------
// Takes one event beat per clock unless the output stalls, and gives one
// result beat per event: the event lands in an input register, the state
// update and result are formed in one pass of logic, and the result waits in
// an output register. While a result is stalled the input register takes one
// more event and then holds in_tready low until the output register is taken,
// so a full throughput of one event per cycle holds whenever the downstream
// side takes beats. Configuration writes are taken every cycle
// (cfg_ready is tied high) and must only be issued while no event is in
// flight. Event kinds on in_tuser: 0 button edge, 1 main tick, 2 aux tick,
// 3 no-op that reports the current settings.
module led_blink_dim_controller_unit #(
  parameter int unsigned PWM_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // event channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [0] button_low, [7:1] zero
  input  logic [1:0]                    in_tuser,   // [1:0] func
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] led_on, [1] dim_mode, [4:2] main_prescale, [20:5] main_period,
  // [21] main_restart, [37:22] aux_period, [38] aux_enable, [39] aux_restart
  output logic [39:0]                   out_tdata,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbd_pkg::PERIOD_W-1:0]  cfg_data
);
  import lbd_pkg::*;
  `include "led_blink_dim_controller_unit_defines.svh"

  lbd_cfg_t    cfg;
  lbd_result_t res;

  logic        in_valid_r;
  ev_t         in_func_r;
  logic        in_button_r;
  logic        out_valid_r;
  lbd_result_t out_data_r;
  logic        move;
  logic        step_en;

  // output register frees up when empty or being taken
  assign move      = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && move;
  assign in_tready = !in_valid_r || move;

  lbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbd_core #(
    .PWM_BITS (PWM_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .func       (in_func_r),
    .button_low (in_button_r),
    .cfg        (cfg),
    .res        (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r   <= ev_t'(in_tuser);
      in_button_r <= in_tdata[0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a stalled event is never dropped from the input register
  `LBD_ASSERT_NEXT(a_in_hold, in_valid_r && !move, in_valid_r, "stalled event lost")
  // each processed event produces a result beat
  `LBD_ASSERT_NEXT(a_step_out, step_en, out_valid_r, "event stepped without result")

endmodule
